// ----- hdl/zsn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_pkg
// Shared widths, point type and coordinate decoding for the 2-D z-score unit.
// ----------------------------------------------------------------------------
package zsn_pkg;

	localparam int DEF_MAX_POINTS = 64;
	localparam int DEF_COORD_BITS = 16;

	localparam int FIELD_W = 16;           // width of one coordinate field
	localparam int VAL_W   = 17;           // decoded coordinate, signed
	localparam int N_W     = 7;            // point count, up to 64
	localparam int SUM_W   = 23;           // signed sum of up to 64 values
	localparam int SQ_W    = 39;           // sum of up to 64 squares
	localparam int PROD_W  = 2 * VAL_W;    // one square
	localparam int M_W     = 45;           // N*sum(v*v) - S*S
	localparam int MEAN_W  = 24;           // unsaturated rounded mean
	localparam int DEV_W   = 16;           // rounded deviation
	localparam int DIV_W   = 32;           // divider dividend and quotient
	localparam int DVS_W   = 17;           // divider divisor
	localparam int OUT_W   = 16;

	typedef struct packed {
		logic [FIELD_W-1:0] y;
		logic [FIELD_W-1:0] x;
	} point_t;

	// decode a raw field as a cb-bit two's complement value; above 16 bits unsigned
	function automatic logic signed [VAL_W-1:0] coord_of(logic [FIELD_W-1:0] raw, int cb);
		int v;
		v = int'(raw);
		if (cb < FIELD_W) begin
			v = v & ((1 << cb) - 1);
			if (((v >> (cb - 1)) & 1) != 0)
				v = v - (1 << cb);
		end else if (cb == FIELD_W) begin
			if (raw[FIELD_W-1])
				v = v - (1 << FIELD_W);
		end
		return VAL_W'(v);
	endfunction

	// clamp a wide signed value to the signed 16-bit range
	function automatic logic [OUT_W-1:0] sat16(logic signed [MEAN_W-1:0] v);
		logic [OUT_W-1:0] r;
		if (v > MEAN_W'(32767))
			r = 16'h7fff;
		else if (v < -MEAN_W'(32768))
			r = 16'h8000;
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

// ----- hdl/zsn_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_store
// Point memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module zsn_store #(
	parameter int DEPTH = zsn_pkg::DEF_MAX_POINTS,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  zsn_pkg::point_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output zsn_pkg::point_t rd_data
);
	import zsn_pkg::*;

	point_t mem [DEPTH];
	point_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/zsn_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module zsn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [zsn_pkg::DIV_W-1:0]  dividend,
	input  logic [zsn_pkg::DVS_W-1:0]  divisor,
	output logic                       busy,
	output logic                       done,
	output logic [zsn_pkg::DIV_W-1:0]  quot
);
	import zsn_pkg::*;

	localparam int CW = $clog2(DIV_W);

	logic             busy_q, done_q;
	logic [CW-1:0]    step_q;
	logic [DIV_W-1:0] dvd_q, quot_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_q, rem_sh;
	logic             fits;

	// trial subtract of the shifted remainder
	assign rem_sh = {rem_q[DVS_W-1:0], dvd_q[DIV_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			dvs_q  <= divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q  <= fits ? rem_sh - {1'b0, dvs_q} : rem_sh;
			quot_q <= {quot_q[DIV_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = quot_q;

endmodule

// ----- hdl/zsn_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_sqrt
// Rounded deviation: largest d with ((2d-1)*n)^2 <= 4m, each bit set by a multiply then a compare phase.
// ----------------------------------------------------------------------------
module zsn_sqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [zsn_pkg::M_W-1:0]   m,
	input  logic [zsn_pkg::N_W-1:0]   n,
	output logic                      busy,
	output logic                      done,
	output logic [zsn_pkg::DEV_W-1:0] root
);
	import zsn_pkg::*;

	localparam int BW = $clog2(DEV_W);
	localparam int T_W = DEV_W + 1 + N_W;

	logic             busy_q, done_q, phase_q;
	logic [BW-1:0]    bit_q;
	logic [DEV_W-1:0] root_q, cand;
	logic [M_W+1:0]   four_m_q;
	logic [N_W-1:0]   n_q;
	logic [T_W-1:0]   t_s1;

	assign cand = root_q | (DEV_W'(1) << bit_q);

	// bit sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			bit_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				bit_q   <= BW'(DEV_W - 1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (bit_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
			end
		end
	end

	// multiply, then square and compare
	always_ff @(posedge clk) begin
		if (start) begin
			root_q   <= '0;
			four_m_q <= {m, 2'b00};
			n_q      <= n;
		end else if (busy_q) begin
			if (!phase_q)
				t_s1 <= T_W'({1'b0, cand, 1'b0} - 18'd1) * T_W'(n_q);
			else if ((2*T_W)'(t_s1) * (2*T_W)'(t_s1) <= (2*T_W)'(four_m_q))
				root_q <= cand;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

// ----- hdl/zscore_normalize_2d_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_normalize_2d_unit
// Collects a set of 2-D Q8.8 points, then emits each normalised to Q4.12.
// ----------------------------------------------------------------------------
//  channel  | handshake                    | payload
//  sample   | sample_valid / sample_ready  | coord_x, coord_y, last_sample
//  result   | result_valid / result_ready  | norm_*, center_*, spread_*, flags
//
//  Points load one per cycle into the point memory while the unit is in its
//  load state; sums and squares build up. Closing a set runs two means on the
//  divider, the variance terms, then two deviations on the square-root unit.
//  Each result then takes a memory read and a division per axis that is not flat.
//  No clearing pass after reset; a result stalled on ready holds the unit.
// ----------------------------------------------------------------------------
module zscore_normalize_2d_unit #(
	parameter int MAX_POINTS = zsn_pkg::DEF_MAX_POINTS,
	parameter int COORD_BITS = zsn_pkg::DEF_COORD_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [15:0]         coord_x,
	input  logic signed [15:0]         coord_y,
	input  logic                       last_sample,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [15:0]         norm_x,
	output logic signed [15:0]         norm_y,
	output logic signed [15:0]         center_x,
	output logic signed [15:0]         center_y,
	output logic [15:0]                spread_x,
	output logic [15:0]                spread_y,
	output logic                       final_item,
	output logic                       flat_x,
	output logic                       flat_y,
	output logic                       dropped
);
	import zsn_pkg::*;

	localparam int AW    = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	localparam logic [3:0] ST_LOAD = 4'd0;
	localparam logic [3:0] ST_MX   = 4'd1;
	localparam logic [3:0] ST_MY   = 4'd2;
	localparam logic [3:0] ST_MSQ  = 4'd3;
	localparam logic [3:0] ST_MSUB = 4'd4;
	localparam logic [3:0] ST_SQX  = 4'd5;
	localparam logic [3:0] ST_SQY  = 4'd6;
	localparam logic [3:0] ST_RD   = 4'd7;
	localparam logic [3:0] ST_NX   = 4'd8;
	localparam logic [3:0] ST_NY   = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	logic [3:0] state_q;
	logic       go_q;

	// accumulation state
	logic [CNT_W-1:0]        cnt_q, emit_q;
	logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
	logic [SQ_W-1:0]         sq_x_q, sq_y_q;
	logic                    ovf_q;
	logic                    prod_vld_s1;
	logic [PROD_W-1:0]       prod_x_s1, prod_y_s1;

	// statistics
	logic signed [MEAN_W-1:0] mean_x_q, mean_y_q;
	logic [DEV_W-1:0]         dev_x_q, dev_y_q;
	logic [M_W:0]             nsq_x_q, nsq_y_q, ss_x_q, ss_y_q;
	logic [M_W-1:0]           m_x_q, m_y_q;
	logic [OUT_W-1:0]         nx_q, ny_q;

	// result register
	logic             out_vld_q, out_fin_q, out_flx_q, out_fly_q, out_drp_q;
	logic [OUT_W-1:0] out_nx_q, out_ny_q, out_cx_q, out_cy_q, out_sx_q, out_sy_q;

	logic                    accept, store_ok, last_emit, out_free;
	logic signed [VAL_W-1:0] x_in, y_in, px, py, pv;
	logic [N_W-1:0]          n7;
	point_t                  wr_pt, rd_pt;

	logic                    div_start, div_busy, div_done;
	logic [DIV_W-1:0]        div_dvd, div_quot;
	logic [DVS_W-1:0]        div_dvs;
	logic                    sq_start, sq_busy, sq_done;
	logic [DEV_W-1:0]        sq_root;

	logic signed [SUM_W-1:0]  s_sel;
	logic [SUM_W-1:0]         s_abs;
	logic signed [MEAN_W-1:0] mn_sel, mean_new;
	logic [DEV_W-1:0]         dv_sel;
	logic signed [MEAN_W:0]   diff;
	logic [MEAN_W:0]          mag;
	logic                     neg_d;
	logic [OUT_W-1:0]         norm_new;

	// input side
	assign sample_ready = (state_q == ST_LOAD);
	assign accept       = sample_valid && sample_ready;
	assign store_ok     = cnt_q < CNT_W'(MAX_POINTS);
	assign x_in         = coord_of(coord_x, COORD_BITS);
	assign y_in         = coord_of(coord_y, COORD_BITS);
	assign wr_pt.x      = coord_x;
	assign wr_pt.y      = coord_y;
	assign n7           = N_W'(cnt_q);
	assign last_emit    = emit_q == cnt_q - 1'b1;
	assign out_free     = !out_vld_q || result_ready;

	zsn_store #(.DEPTH(MAX_POINTS), .AW(AW)) u_store (
		.clk     (clk),
		.wr_en   (accept && store_ok),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (wr_pt),
		.rd_en   (state_q == ST_RD),
		.rd_addr (emit_q[AW-1:0]),
		.rd_data (rd_pt)
	);

	assign px = coord_of(rd_pt.x, COORD_BITS);
	assign py = coord_of(rd_pt.y, COORD_BITS);

	// mean division operands
	assign s_sel = (state_q == ST_MX) ? sum_x_q : sum_y_q;
	assign s_abs = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);
	assign mean_new = s_sel[SUM_W-1] ? -MEAN_W'(div_quot) : MEAN_W'(div_quot);

	// normalisation operands
	assign pv     = (state_q == ST_NX) ? px : py;
	assign mn_sel = (state_q == ST_NX) ? mean_x_q : mean_y_q;
	assign dv_sel = (state_q == ST_NX) ? dev_x_q : dev_y_q;
	assign diff   = (MEAN_W+1)'(pv) - (MEAN_W+1)'(mn_sel);
	assign neg_d  = diff[MEAN_W];
	assign mag    = neg_d ? (MEAN_W+1)'(-diff) : (MEAN_W+1)'(diff);

	always_comb begin
		if (state_q == ST_MX || state_q == ST_MY) begin
			div_dvd = DIV_W'({s_abs, 1'b0}) + DIV_W'(n7);
			div_dvs = DVS_W'({n7, 1'b0});
		end else begin
			div_dvd = DIV_W'({mag, 13'b0}) + DIV_W'(dv_sel);
			div_dvs = DVS_W'({dv_sel, 1'b0});
		end
	end

	// saturate the rounded quotient to Q4.12
	always_comb begin
		if (neg_d)
			norm_new = (div_quot > DIV_W'(32768)) ? 16'h8000 : OUT_W'(-div_quot);
		else
			norm_new = (div_quot > DIV_W'(32767)) ? 16'h7fff : OUT_W'(div_quot);
	end

	assign div_start = !go_q && (state_q == ST_MX || state_q == ST_MY
		|| (state_q == ST_NX && dev_x_q != '0) || (state_q == ST_NY && dev_y_q != '0));
	assign sq_start  = !go_q && (state_q == ST_SQX || state_q == ST_SQY);

	zsn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot)
	);

	zsn_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.m      ((state_q == ST_SQX) ? m_x_q : m_y_q),
		.n      (n7),
		.busy   (sq_busy),
		.done   (sq_done),
		.root   (sq_root)
	);

	// squares of stored points, one stage before the accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prod_vld_s1 <= 1'b0;
		else
			prod_vld_s1 <= accept && store_ok;
	end

	always_ff @(posedge clk) begin
		prod_x_s1 <= PROD_W'(x_in * x_in);
		prod_y_s1 <= PROD_W'(y_in * y_in);
	end

	// variance terms
	always_ff @(posedge clk) begin
		if (state_q == ST_MSQ) begin
			nsq_x_q <= (M_W+1)'(n7 * sq_x_q);
			nsq_y_q <= (M_W+1)'(n7 * sq_y_q);
			ss_x_q  <= (M_W+1)'(sum_x_q * sum_x_q);
			ss_y_q  <= (M_W+1)'(sum_y_q * sum_y_q);
		end
		if (state_q == ST_MSUB) begin
			m_x_q <= M_W'(nsq_x_q - ss_x_q);
			m_y_q <= M_W'(nsq_y_q - ss_y_q);
		end
	end

	// sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			go_q      <= 1'b0;
			cnt_q     <= '0;
			emit_q    <= '0;
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			sq_x_q    <= '0;
			sq_y_q    <= '0;
			ovf_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (prod_vld_s1) begin
				sq_x_q <= sq_x_q + SQ_W'(prod_x_s1);
				sq_y_q <= sq_y_q + SQ_W'(prod_y_s1);
			end
			if (out_vld_q && result_ready && !(state_q == ST_OUT && out_free))
				out_vld_q <= 1'b0;
			if (div_start || sq_start)
				go_q <= 1'b1;
			if (div_done || sq_done)
				go_q <= 1'b0;

			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (store_ok) begin
							cnt_q   <= cnt_q + 1'b1;
							sum_x_q <= sum_x_q + SUM_W'(x_in);
							sum_y_q <= sum_y_q + SUM_W'(y_in);
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_sample)
							state_q <= ST_MX;
					end
				end
				ST_MX: if (div_done) state_q <= ST_MY;
				ST_MY: if (div_done) state_q <= ST_MSQ;
				ST_MSQ: state_q <= ST_MSUB;
				ST_MSUB: state_q <= ST_SQX;
				ST_SQX: if (sq_done) state_q <= ST_SQY;
				ST_SQY: begin
					if (sq_done) begin
						emit_q  <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: state_q <= ST_NX;
				ST_NX: if (dev_x_q == '0 || div_done) state_q <= ST_NY;
				ST_NY: if (dev_y_q == '0 || div_done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						if (last_emit) begin
							cnt_q   <= '0;
							sum_x_q <= '0;
							sum_y_q <= '0;
							sq_x_q  <= '0;
							sq_y_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_LOAD;
						end else begin
							emit_q  <= emit_q + 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// statistics and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_MX && div_done) mean_x_q <= mean_new;
		if (state_q == ST_MY && div_done) mean_y_q <= mean_new;
		if (state_q == ST_SQX && sq_done) dev_x_q <= sq_root;
		if (state_q == ST_SQY && sq_done) dev_y_q <= sq_root;
		if (state_q == ST_NX) nx_q <= (dev_x_q == '0) ? '0 : norm_new;
		if (state_q == ST_NY) ny_q <= (dev_y_q == '0) ? '0 : norm_new;
		if (state_q == ST_OUT && out_free) begin
			out_nx_q  <= nx_q;
			out_ny_q  <= ny_q;
			out_cx_q  <= sat16(mean_x_q);
			out_cy_q  <= sat16(mean_y_q);
			out_sx_q  <= dev_x_q;
			out_sy_q  <= dev_y_q;
			out_fin_q <= last_emit;
			out_flx_q <= dev_x_q == '0;
			out_fly_q <= dev_y_q == '0;
			out_drp_q <= ovf_q;
		end
	end

	assign result_valid = out_vld_q;
	assign norm_x       = out_nx_q;
	assign norm_y       = out_ny_q;
	assign center_x     = out_cx_q;
	assign center_y     = out_cy_q;
	assign spread_x     = out_sx_q;
	assign spread_y     = out_sy_q;
	assign final_item   = out_fin_q;
	assign flat_x       = out_flx_q;
	assign flat_y       = out_fly_q;
	assign dropped      = out_drp_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count above capacity");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready |-> !div_busy && !sq_busy)
		else $error("loading while arithmetic units busy");

	a_flat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && flat_x |-> norm_x == '0 && spread_x == '0)
		else $error("flat axis with nonzero result");

endmodule

// ----- dv/zscore_normalize_2d_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_normalize_2d_unit_test
// Sends sets of 2-D Q8.8 points to the z-score unit, with random gaps on the
// sample side and random stalls on the result side. Each sample transaction
// updates a local model of the point store. When a set closes, the model
// works out the mean, the deviation and the normalised value of every stored
// point. Each result transaction is then checked field by field against the
// oldest expected result.
// ----------------------------------------------------------------------------
module zscore_normalize_2d_unit_test;
	import zsn_pkg::*;

	localparam int POINTS_CAP  = DEF_MAX_POINTS;
	localparam int TOTAL_ITEMS = 470;

	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] cx;
		logic [15:0] cy;
		logic [15:0] sx;
		logic [15:0] sy;
		logic        fin;
		logic        fx;
		logic        fy;
		logic        drop;
	} zresult_t;

	// running model of the unit and the queue of normalised points it owes
	class zscore_scoreboard;
		longint   px[POINTS_CAP];
		longint   py[POINTS_CAP];
		int       held;
		bit       overflowed;
		zresult_t owed[$];
		int       errors;

		function void clear_set();
			held       = 0;
			overflowed = 0;
		endfunction

		function longint rounded_mean(longint s, longint n);
			longint mag;
			longint q;
			mag = s < 0 ? -s : s;
			q   = (2 * mag + n) / (2 * n);
			return s < 0 ? -q : q;
		endfunction

		// largest d with ((2d-1)n)^2 <= 4M, i.e. sqrt(M)/n rounded, halves up
		function longint rounded_dev(longint m, longint n);
			longint lo;
			longint hi;
			longint mid;
			longint t;
			lo = 0;
			hi = 65535;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				t   = (2 * mid - 1) * n;
				if (t * t <= 4 * m)
					lo = mid;
				else
					hi = mid - 1;
			end
			return lo;
		endfunction

		function logic [15:0] zscore(longint v, longint mean, longint dev);
			longint d;
			longint q;
			if (dev == 0)
				return 16'h0000;
			d = v - mean;
			q = (2 * ((d < 0 ? -d : d) * 4096) + dev) / (2 * dev);
			if (d < 0) begin
				if (q > 32768)
					q = 32768;
				q = -q;
			end else if (q > 32767) begin
				q = 32767;
			end
			return q[15:0];
		endfunction

		function logic [15:0] clamp16(longint v);
			if (v > 32767)
				v = 32767;
			if (v < -32768)
				v = -32768;
			return v[15:0];
		endfunction

		// note an accepted sample transaction
		function void note_point(logic signed [15:0] x, logic signed [15:0] y, logic closes);
			longint   sx, sy, qx, qy, n, mx, my, dx, dy;
			zresult_t r;
			if (held < POINTS_CAP) begin
				px[held] = x;
				py[held] = y;
				held++;
			end else begin
				overflowed = 1;
			end
			if (!closes)
				return;
			n  = held;
			sx = 0;
			sy = 0;
			qx = 0;
			qy = 0;
			for (int i = 0; i < held; i++) begin
				sx += px[i];
				sy += py[i];
				qx += px[i] * px[i];
				qy += py[i] * py[i];
			end
			mx = rounded_mean(sx, n);
			my = rounded_mean(sy, n);
			dx = rounded_dev(n * qx - sx * sx, n);
			dy = rounded_dev(n * qy - sy * sy, n);
			for (int i = 0; i < held; i++) begin
				r.nx   = zscore(px[i], mx, dx);
				r.ny   = zscore(py[i], my, dy);
				r.cx   = clamp16(mx);
				r.cy   = clamp16(my);
				r.sx   = dx[15:0];
				r.sy   = dy[15:0];
				r.fin  = (i == held - 1);
				r.fx   = (dx == 0);
				r.fy   = (dy == 0);
				r.drop = overflowed;
				owed.push_back(r);
			end
			clear_set();
		endfunction

		// check one result transaction against the oldest expectation
		function void check_result(zresult_t a);
			zresult_t e;
			if (owed.size() == 0) begin
				$error("unexpected result transaction: norm_x %0d norm_y %0d",
					$signed(a.nx), $signed(a.ny));
				errors++;
				return;
			end
			e = owed.pop_front();
			if (a.nx !== e.nx) begin
				$error("norm_x exp %0d got %0d", $signed(e.nx), $signed(a.nx)); errors++;
			end
			if (a.ny !== e.ny) begin
				$error("norm_y exp %0d got %0d", $signed(e.ny), $signed(a.ny)); errors++;
			end
			if (a.cx !== e.cx) begin
				$error("center_x exp %0d got %0d", $signed(e.cx), $signed(a.cx)); errors++;
			end
			if (a.cy !== e.cy) begin
				$error("center_y exp %0d got %0d", $signed(e.cy), $signed(a.cy)); errors++;
			end
			if (a.sx !== e.sx) begin
				$error("spread_x exp %0d got %0d", e.sx, a.sx); errors++;
			end
			if (a.sy !== e.sy) begin
				$error("spread_y exp %0d got %0d", e.sy, a.sy); errors++;
			end
			if (a.fin !== e.fin) begin
				$error("final_item exp %0b got %0b", e.fin, a.fin); errors++;
			end
			if (a.fx !== e.fx) begin
				$error("flat_x exp %0b got %0b", e.fx, a.fx); errors++;
			end
			if (a.fy !== e.fy) begin
				$error("flat_y exp %0b got %0b", e.fy, a.fy); errors++;
			end
			if (a.drop !== e.drop) begin
				$error("dropped exp %0b got %0b", e.drop, a.drop); errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_ready;
	logic signed [15:0] coord_x;
	logic signed [15:0] coord_y;
	logic               last_sample;
	logic               result_valid;
	logic               result_ready;
	logic signed [15:0] norm_x;
	logic signed [15:0] norm_y;
	logic signed [15:0] center_x;
	logic signed [15:0] center_y;
	logic [15:0]        spread_x;
	logic [15:0]        spread_y;
	logic               final_item;
	logic               flat_x;
	logic               flat_y;
	logic               dropped;

	zscore_scoreboard sb;
	int               sent;
	bit               calm;

	zscore_normalize_2d_unit i_dut (.*);

	// clock
	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// run limit
	initial begin
		#4ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// one sample transaction, preceded by a random gap
	task automatic send_point(logic [15:0] x, logic [15:0] y, logic closes);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		coord_x      <= x;
		coord_y      <= y;
		last_sample  <= closes;
		do
			@(posedge clk);
		while (!sample_ready);
		sb.note_point(x, y, closes);
		sent++;
	endtask

	// a set of given size; kind picks the shape of the content
	task automatic send_set(int size, int kind);
		logic [15:0] bx, by, x, y;
		int          odd;
		bx  = 16'($urandom);
		by  = 16'($urandom);
		odd = $urandom_range(0, size - 1);
		for (int i = 0; i < size; i++) begin
			x = 16'($urandom);
			y = 16'($urandom);
			case (kind)
				1: begin
					x = bx + 16'($urandom_range(0, 255)) - 16'd128;
					y = by + 16'($urandom_range(0, 255)) - 16'd128;
				end
				2: x = bx;
				3: y = by;
				4: begin
					x = (i == odd) ? x : bx;
					y = (i == odd) ? y : by;
				end
				default: ;
			endcase
			send_point(x, y, i == size - 1);
		end
	endtask

	// result side: random stalls, check every transaction
	initial begin
		int       stall;
		zresult_t got;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do
				@(posedge clk);
			while (!result_valid);
			got = '{norm_x, norm_y, center_x, center_y, spread_x, spread_y,
				final_item, flat_x, flat_y, dropped};
			sb.check_result(got);
		end
	end

	// stimulus and end of run
	initial begin
		int size;
		int pick;
		int guard;
		sb = new();
		sb.clear_set();
		sent         = 0;
		calm         = 0;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		coord_x      = '0;
		coord_y      = '0;
		last_sample  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single point: both axes flat
		send_point(16'h0000, 16'h0000, 1'b1);
		// opposite extremes
		send_point(16'h8000, 16'h7fff, 1'b0);
		send_point(16'h7fff, 16'h8000, 1'b1);
		// constant first axis
		send_point(16'h1234, 16'h8000, 1'b0);
		send_point(16'h1234, 16'h0001, 1'b0);
		send_point(16'h1234, 16'h7fff, 1'b1);
		// constant second axis, first-axis mean exactly halfway for mean rounding
		send_point(16'hffff, 16'h8000, 1'b0);
		send_point(16'h0000, 16'h8000, 1'b0);
		send_point(16'hfffe, 16'h8000, 1'b0);
		send_point(16'h0001, 16'h8000, 1'b1);

		// random sets: mostly short, some near or at capacity, some beyond it
		while (sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				calm = !calm;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				size = $urandom_range(65, 70);
			else if (pick == 1)
				size = $urandom_range(56, 64);
			else
				size = $urandom_range(1, 9);
			send_set(size, $urandom_range(0, 4));
		end
		sample_valid <= 1'b0;

		guard = 0;
		while (sb.owed.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (400) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
